@@ src/imufd_pkg.sv @@
// Shared types and constants of the IMU frame deframer.
// Used by the front end, the job queue, the back end and the top level.
package imufd_pkg;

    localparam logic [7:0] HDR_BYTE    = 8'hA6;
    localparam int         POS_W       = 5;
    localparam logic [POS_W-1:0] POS_HUNT    = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR2    = 5'd1;
    localparam logic [POS_W-1:0] POS_INDEX   = 5'd2;
    localparam logic [POS_W-1:0] POS_CHECK   = 5'd25;
    localparam int         CAP_LEN     = 19;
    localparam logic [POS_W-1:0] CAP_LEN_POS = 5'd19;

    localparam int         NAXES       = 3;
    localparam int         DIFF_W      = 17;
    localparam logic signed [DIFF_W-1:0] HALF_TURN = 17'sd18000;
    localparam logic signed [DIFF_W-1:0] FULL_TURN = 17'sd36000;

    localparam logic       REQ_BYTE    = 1'b0;
    localparam logic       REQ_ZERO    = 1'b1;

    localparam logic [1:0] AXIS_ROLL   = 2'd0;
    localparam logic [1:0] AXIS_PITCH  = 2'd1;
    localparam logic [1:0] AXIS_YAW    = 2'd2;

    localparam logic       STATUS_OK   = 1'b0;
    localparam logic       STATUS_BAD  = 1'b1;

    localparam int         QUEUE_DEPTH = 2;

    // One finished frame on its way from the front end to the back end.
    // The angle fields hold raw minus offset, not yet wrapped.
    typedef struct packed {
        logic                         status;
        logic [7:0]                   index;
        logic [NAXES-1:0][DIFF_W-1:0] diff;
        logic [NAXES-1:0][15:0]       rate;
        logic [NAXES-1:0][15:0]       accel;
    } t_job;

endpackage

@@ src/imufd_front.sv @@
// Front end: header hunt, checksum, field capture and angle offsets.
// Emits one job per finished frame with a new index. Uses imufd_pkg.
module imufd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic               i_req_type,
    input  logic [7:0]         i_rx_byte,
    input  logic [1:0]         i_axis,
    output logic               o_push,
    output imufd_pkg::t_job    o_job
);
    import imufd_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_prev, n_prev;
    logic [15:0]      r_raw [NAXES];
    logic [15:0]      n_raw [NAXES];
    logic [15:0]      r_offs [NAXES];
    logic [15:0]      n_offs [NAXES];
    logic [7:0]       r_cap [CAP_LEN];
    logic             w_cap_we;
    logic [POS_W-1:0] w_cap_idx;

    assign w_cap_idx = r_pos - POS_INDEX;

    always_comb begin
        n_pos    = r_pos;
        n_sum    = r_sum;
        n_prev   = r_prev;
        n_raw    = r_raw;
        n_offs   = r_offs;
        w_cap_we = 1'b0;
        o_push   = 1'b0;
        o_job    = '0;
        if (i_accept) begin
            if (i_req_type == REQ_ZERO) begin
                unique case (i_axis)
                    AXIS_ROLL:  n_offs[0] = r_raw[0];
                    AXIS_PITCH: n_offs[1] = r_raw[1];
                    AXIS_YAW:   n_offs[2] = r_raw[2];
                    default:    ;
                endcase
            end else begin
                priority if (r_pos == POS_HUNT) begin
                    if (i_rx_byte == HDR_BYTE) begin
                        n_pos = POS_HDR2;
                    end
                end else if (r_pos == POS_HDR2) begin
                    n_pos = (i_rx_byte == HDR_BYTE) ? POS_INDEX : POS_HUNT;
                end else if (r_pos >= POS_CHECK) begin
                    n_pos = POS_HUNT;
                    // A frame that repeats the last index is dropped silently.
                    if (r_cap[0] != r_prev) begin
                        o_push      = 1'b1;
                        n_prev      = r_cap[0];
                        o_job.index = r_cap[0];
                        if (r_sum != i_rx_byte) begin
                            o_job.status = STATUS_BAD;
                        end else begin
                            o_job.status = STATUS_OK;
                            for (int j = 0; j < NAXES; j++) begin
                                n_raw[j]       = {r_cap[2+2*j], r_cap[1+2*j]};
                                o_job.diff[j]  = {n_raw[j][15], n_raw[j]}
                                               - {r_offs[j][15], r_offs[j]};
                                o_job.rate[j]  = {r_cap[8+2*j], r_cap[7+2*j]};
                                o_job.accel[j] = {r_cap[14+2*j], r_cap[13+2*j]};
                            end
                        end
                    end
                end else begin
                    n_sum    = (r_pos == POS_INDEX) ? i_rx_byte : r_sum + i_rx_byte;
                    w_cap_we = (w_cap_idx < CAP_LEN_POS);
                    n_pos    = r_pos + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_HUNT;
            r_sum  <= '0;
            r_prev <= '0;
            for (int j = 0; j < NAXES; j++) begin
                r_raw[j]  <= '0;
                r_offs[j] <= '0;
            end
        end else begin
            r_pos  <= n_pos;
            r_sum  <= n_sum;
            r_prev <= n_prev;
            r_raw  <= n_raw;
            r_offs <= n_offs;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CAP_LEN; k++) begin
            if (w_cap_we && w_cap_idx == POS_W'(k)) begin
                r_cap[k] <= i_rx_byte;
            end
        end
    end

endmodule

@@ src/imufd_queue.sv @@
// Short job queue between the front end and the back end.
// Holds imufd_pkg::t_job entries; the head entry is read without delay.
module imufd_queue #(
    parameter int DEPTH = imufd_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  imufd_pkg::t_job    i_data,
    output logic               o_full,
    input  logic               i_pop,
    output imufd_pkg::t_job    o_data,
    output logic               o_empty
);
    import imufd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (i_pop) begin
                r_rd <= next_ptr(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ src/imufd_back.sv @@
// Back end: wraps the zeroed angles into one turn and holds the result word
// in the output register. Uses imufd_pkg.
module imufd_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  imufd_pkg::t_job    i_job,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_status,
    output logic [7:0]         o_frame_index,
    output logic signed [15:0] o_roll_angle,
    output logic signed [15:0] o_pitch_angle,
    output logic signed [15:0] o_yaw_angle,
    output logic signed [15:0] o_roll_rate,
    output logic signed [15:0] o_pitch_rate,
    output logic signed [15:0] o_yaw_rate,
    output logic [15:0]        o_roll_accel,
    output logic [15:0]        o_pitch_accel,
    output logic [15:0]        o_yaw_accel
);
    import imufd_pkg::*;

    logic              r_valid;
    t_job              r_job;
    t_job              w_wrapped;
    logic [NAXES-1:0][15:0] w_angle;

    function automatic logic [15:0] wrap_turn(input logic signed [DIFF_W-1:0] d);
        logic signed [DIFF_W-1:0] w;
        priority if (d > HALF_TURN) begin
            w = d - FULL_TURN;
        end else if (d < -HALF_TURN) begin
            w = d + FULL_TURN;
        end else begin
            w = d;
        end
        return w[15:0];
    endfunction

    assign o_pop = !i_q_empty && (!r_valid || !i_stall);

    always_comb begin
        w_wrapped = i_job;
        for (int j = 0; j < NAXES; j++) begin
            w_wrapped.diff[j] = {1'b0, wrap_turn($signed(i_job.diff[j]))};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_stall) begin
            r_valid <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= w_wrapped;
        end
    end

    for (genvar j = 0; j < NAXES; j++) begin : g_angle
        assign w_angle[j] = r_job.diff[j][15:0];
    end

    assign o_valid       = r_valid;
    assign o_status      = r_job.status;
    assign o_frame_index = r_job.index;
    assign o_roll_angle  = $signed(w_angle[0]);
    assign o_pitch_angle = $signed(w_angle[1]);
    assign o_yaw_angle   = $signed(w_angle[2]);
    assign o_roll_rate   = $signed(r_job.rate[0]);
    assign o_pitch_rate  = $signed(r_job.rate[1]);
    assign o_yaw_rate    = $signed(r_job.rate[2]);
    assign o_roll_accel  = r_job.accel[0];
    assign o_pitch_accel = r_job.accel[1];
    assign o_yaw_accel   = r_job.accel[2];

endmodule

@@ src/imu_frame_deframer_with_angle_zero_core.sv @@
// IMU frame deframer with per-axis angle zeroing.
// Input channel: one word per accepted item. A word with i_req_type low carries
// a received serial byte in i_rx_byte; with i_req_type high it zeroes the axis
// in i_axis (axis code 3 is ignored). Frames are 26 bytes starting with two
// 0xA6 header bytes; the last byte is the checksum of bytes 2 to 24.
// Output channel: one result word per finished frame whose index differs from
// the last one seen. Status low carries the zeroed, wrapped angles, rates and
// accelerations; status high flags a checksum mismatch with zeroed data.
// Throughput: one input word per cycle while o_stall is low. A result reaches
// o_valid once the front end has decoded the checksum byte into the job queue
// and the back end has wrapped the angles into the output register.
// When the receiver asserts i_stall the output register holds its word and the
// job queue (QUEUE_DEPTH entries) absorbs further frames; o_stall rises only
// when the queue is full. Reset clears the header hunt, the checksum, the last
// index, the raw angles and the offsets to zero and empties the queue.
module imu_frame_deframer_with_angle_zero_core #(
    parameter int QUEUE_DEPTH = imufd_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_req_type,
    input  logic [7:0]         i_rx_byte,
    input  logic [1:0]         i_axis,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_status,
    output logic [7:0]         o_frame_index,
    output logic signed [15:0] o_roll_angle,
    output logic signed [15:0] o_pitch_angle,
    output logic signed [15:0] o_yaw_angle,
    output logic signed [15:0] o_roll_rate,
    output logic signed [15:0] o_pitch_rate,
    output logic signed [15:0] o_yaw_rate,
    output logic [15:0]        o_roll_accel,
    output logic [15:0]        o_pitch_accel,
    output logic [15:0]        o_yaw_accel
);
    import imufd_pkg::*;

    logic w_accept;
    logic w_push, w_pop, w_full, w_empty;
    t_job w_front_job, w_head_job;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    imufd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .i_axis     (i_axis),
        .o_push     (w_push),
        .o_job      (w_front_job)
    );

    imufd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_head_job),
        .o_empty (w_empty)
    );

    imufd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (w_empty),
        .i_job         (w_head_job),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_frame_index (o_frame_index),
        .o_roll_angle  (o_roll_angle),
        .o_pitch_angle (o_pitch_angle),
        .o_yaw_angle   (o_yaw_angle),
        .o_roll_rate   (o_roll_rate),
        .o_pitch_rate  (o_pitch_rate),
        .o_yaw_rate    (o_yaw_rate),
        .o_roll_accel  (o_roll_accel),
        .o_pitch_accel (o_pitch_accel),
        .o_yaw_accel   (o_yaw_accel)
    );

    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into a full queue");

    a_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job popped from an empty queue");

    a_bad_frame_zeroed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STATUS_BAD) |->
        (o_roll_angle == 16'sd0 && o_yaw_rate == 16'sd0 && o_yaw_accel == 16'd0))
        else $error("checksum error result carries data");

endmodule
